### sv/hlac_pkg.sv
// Shared types, constants and helpers of the length-prefixed to Annex B converter.
`default_nettype none
package hlac_pkg;

	localparam int unsigned DATA_W      = 8;
	localparam int unsigned TIME_W      = 32;
	localparam int unsigned MASK_W      = 64;
	localparam int unsigned LEN_W       = 32;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned IDX_W       = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_VCL_MASK   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_PARAM_MASK = CFG_IDX_W'(1);

	localparam logic [MASK_W-1:0] VCL_MASK_RST   = 64'h0000_0000_003F_03FF;
	localparam logic [MASK_W-1:0] PARAM_MASK_RST = 64'h0000_0007_0000_0000;

	localparam logic [5:0] AUD_TYPE  = 6'd35;
	localparam logic [2:0] LEN_BYTES = 3'd4;

	// Last byte index of each output run (prefix bytes then the payload byte)
	localparam logic [IDX_W-1:0] LONG_LAST   = 4'd11;
	localparam logic [IDX_W-1:0] CONFIG_LAST = 4'd4;
	localparam logic [IDX_W-1:0] SHORT_LAST  = 4'd3;
	localparam logic [IDX_W-1:0] NONE_LAST   = 4'd0;

	typedef enum logic [1:0] {
		GRP_OTHER  = 2'd0,
		GRP_START  = 2'd1,
		GRP_CONFIG = 2'd2,
		GRP_VCL    = 2'd3
	} grp_t;

	typedef enum logic [1:0] {
		PFX_NONE,
		PFX_SHORT,
		PFX_CONFIG,
		PFX_LONG
	} pfx_t;

	typedef struct packed {
		pfx_t              pfx;
		logic [DATA_W-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Delimiter NAL plus start codes; the 3- and 4-byte codes are slices of it
	function automatic logic [DATA_W-1:0] prefix_byte(input logic [IDX_W-1:0] idx);
		logic [DATA_W-1:0] b;
		b = 8'h00;
		case (idx)
			4'd3:    b = 8'h01;
			4'd4:    b = 8'h46;
			4'd5:    b = 8'h01;
			4'd6:    b = 8'h50;
			4'd10:   b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [IDX_W-1:0] run_last_idx(input pfx_t pfx);
		logic [IDX_W-1:0] l;
		l = NONE_LAST;
		unique case (pfx)
			PFX_LONG:   l = LONG_LAST;
			PFX_CONFIG: l = CONFIG_LAST;
			PFX_SHORT:  l = SHORT_LAST;
			PFX_NONE:   l = NONE_LAST;
			default:    l = NONE_LAST;
		endcase
		return l;
	endfunction

endpackage
`default_nettype wire

### sv/hlac_if.sv
// Stream channel interfaces for the packet input and the Annex B output.
`default_nettype none
interface hlac_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        packet_first;
	logic        packet_last;
	logic [31:0] frame_time;

	modport source(output valid, data_byte, packet_first, packet_last, frame_time,
		input ready);
	modport sink(input valid, data_byte, packet_first, packet_last, frame_time,
		output ready);
endinterface

interface hlac_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;

	modport source(output valid, out_byte, run_last, input ready);
	modport sink(input valid, out_byte, run_last, output ready);
endinterface
`default_nettype wire

### sv/hlac_queue.sv
// Short command queue between the parser and the byte emitter.
`default_nettype none
module hlac_queue #(
	parameter int unsigned DEPTH = hlac_pkg::QUEUE_DEPTH
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  hlac_pkg::cmd_t       din,
	input  wire                  pop,
	output hlac_pkg::cmd_t       dout,
	output hlac_pkg::q_stat_t    stat
);
	import hlac_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign dout       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

### sv/hlac_front.sv
// Packet parser: length fields, NAL header classification and prefix choice.
`default_nettype none
module hlac_front (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     cfg_we,
	input  wire [hlac_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  wire [hlac_pkg::MASK_W-1:0]              cfg_data,
	hlac_in_if.sink                                 in_ch,
	input  hlac_pkg::q_stat_t                       q_stat,
	output logic                                    push,
	output hlac_pkg::cmd_t                          push_cmd
);
	import hlac_pkg::*;

	logic [MASK_W-1:0] vcl_mask_q;
	logic [MASK_W-1:0] param_mask_q;
	logic [TIME_W-1:0] last_time_q;
	grp_t              grp_q;
	logic [2:0]        len_cnt_q;
	logic [LEN_W-1:0]  remain_q;
	logic              drop_q;
	logic              hdr_wait_q;

	logic [TIME_W-1:0] last_time_n;
	grp_t              grp_n;
	logic [2:0]        len_cnt_n;
	logic [LEN_W-1:0]  remain_n;
	logic              drop_n;
	logic              hdr_wait_n;
	logic              emit;
	pfx_t              pfx;
	grp_t              cls;
	logic [5:0]        nal_type;
	logic              accept;

	assign in_ch.ready = !q_stat.full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign push        = accept && emit;
	assign push_cmd    = '{pfx: pfx, data: in_ch.data_byte};
	assign nal_type    = in_ch.data_byte[6:1];

	always_comb begin
		last_time_n = last_time_q;
		grp_n       = grp_q;
		len_cnt_n   = len_cnt_q;
		remain_n    = remain_q;
		drop_n      = drop_q;
		hdr_wait_n  = hdr_wait_q;
		emit        = 1'b0;
		pfx         = PFX_NONE;
		cls         = GRP_OTHER;

		if (in_ch.packet_first) begin
			if (in_ch.frame_time != last_time_q) begin
				last_time_n = in_ch.frame_time;
				grp_n       = GRP_START;
			end
			len_cnt_n  = '0;
			remain_n   = '0;
			drop_n     = 1'b0;
			hdr_wait_n = 1'b0;
		end

		if (hdr_wait_n) begin
			hdr_wait_n = 1'b0;
			remain_n   = remain_n - LEN_W'(1);
			if (nal_type == AUD_TYPE) begin
				// delimiter unit: dropped, restarts the group
				grp_n  = GRP_START;
				drop_n = 1'b1;
			end else begin
				if (vcl_mask_q[nal_type]) begin
					cls = GRP_VCL;
				end else if (param_mask_q[nal_type]) begin
					cls = GRP_CONFIG;
				end else begin
					cls = GRP_OTHER;
				end
				emit = 1'b1;
				if (grp_n == GRP_START || (grp_n != GRP_OTHER && cls != grp_n)) begin
					pfx = PFX_LONG;
				end else if (cls == GRP_CONFIG) begin
					pfx = PFX_CONFIG;
				end else begin
					pfx = PFX_SHORT;
				end
				grp_n  = cls;
				drop_n = 1'b0;
			end
			if (remain_n == '0) begin
				len_cnt_n = '0;
			end
		end else if (len_cnt_n >= LEN_BYTES) begin
			if (remain_n != '0) begin
				remain_n = remain_n - LEN_W'(1);
			end
			if (!drop_n) begin
				emit = 1'b1;
			end
			if (remain_n == '0) begin
				len_cnt_n = '0;
				drop_n    = 1'b0;
			end
		end else begin
			remain_n  = {remain_n[LEN_W-DATA_W-1:0], in_ch.data_byte};
			len_cnt_n = len_cnt_n + 3'd1;
			if (len_cnt_n == LEN_BYTES) begin
				if (remain_n == '0) begin
					len_cnt_n = '0;
				end else begin
					hdr_wait_n = 1'b1;
				end
			end
		end

		if (in_ch.packet_last) begin
			len_cnt_n  = '0;
			remain_n   = '0;
			drop_n     = 1'b0;
			hdr_wait_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcl_mask_q   <= VCL_MASK_RST;
			param_mask_q <= PARAM_MASK_RST;
			last_time_q  <= '0;
			grp_q        <= GRP_START;
			len_cnt_q    <= '0;
			remain_q     <= '0;
			drop_q       <= 1'b0;
			hdr_wait_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_VCL_MASK:   vcl_mask_q   <= cfg_data;
					CFG_PARAM_MASK: param_mask_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				last_time_q <= last_time_n;
				grp_q       <= grp_n;
				len_cnt_q   <= len_cnt_n;
				remain_q    <= remain_n;
				drop_q      <= drop_n;
				hdr_wait_q  <= hdr_wait_n;
			end
		end
	end

endmodule
`default_nettype wire

### sv/hlac_back.sv
// Byte emitter: expands each queued command into prefix bytes and the payload byte.
`default_nettype none
module hlac_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  hlac_pkg::cmd_t       head,
	input  hlac_pkg::q_stat_t    q_stat,
	output logic                 pop,
	hlac_out_if.source           out_ch
);
	import hlac_pkg::*;

	logic [IDX_W-1:0]  idx_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_byte_q;
	logic              run_last_q;

	logic [IDX_W-1:0]  last_idx;
	logic [IDX_W-1:0]  pfx_idx;
	logic              at_last;
	logic              load;
	logic [DATA_W-1:0] next_byte;

	assign last_idx = run_last_idx(head.pfx);
	assign at_last  = (idx_q == last_idx);
	// short start code skips the leading zero of the long one
	assign pfx_idx  = (head.pfx == PFX_SHORT) ? idx_q + IDX_W'(1) : idx_q;
	assign next_byte = at_last ? head.data : prefix_byte(pfx_idx);
	assign load     = !q_stat.empty && (!out_valid_q || out_ch.ready);
	assign pop      = load && at_last;

	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.run_last = run_last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= next_byte;
			run_last_q <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_last ? '0 : idx_q + IDX_W'(1);
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### sv/hevc_length_to_annexb_converter_top.sv
// Top level of the length-prefixed to Annex B converter.
// Path: a byte that produces output is written into the command queue, then into the output register.
// Throughput: one input byte per cycle while the command queue is not full; a unit header expands
// to 4, 5 or 12 output bytes and the command queue absorbs the gap.
// Reset: arst_n clears parser state, masks to defaults, queue and output register at once.
`default_nettype none
module hevc_length_to_annexb_converter_top #(
	parameter int unsigned FIFO_DEPTH = hlac_pkg::QUEUE_DEPTH
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [hlac_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [hlac_pkg::MASK_W-1:0]       cfg_data,
	hlac_in_if.sink                          in_ch,
	hlac_out_if.source                       out_ch
);
	import hlac_pkg::*;

	logic    push;
	logic    pop;
	cmd_t    push_cmd;
	cmd_t    head;
	q_stat_t q_stat;

	hlac_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	hlac_queue #(
		.DEPTH(FIFO_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (push_cmd),
		.pop   (pop),
		.dout  (head),
		.stat  (q_stat)
	);

	hlac_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.q_stat(q_stat),
		.pop   (pop),
		.out_ch(out_ch)
	);

endmodule
`default_nettype wire

### sv/hlac_checker.sv
// Port-level checks of the converter and their attachment to the top level.
`default_nettype none
module hlac_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_ready,
	input wire       out_valid,
	input wire       out_ready,
	input wire [7:0] out_byte
);

	// a stalled output transfer must hold
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte))
		else $error("output byte changed while stalled");

	// output register is only known to be clear from the edge after reset is seen
	a_rst_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid during reset");

	// queue can only be full while the emitter has a byte on offer
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with nothing on the output");

endmodule

bind hevc_length_to_annexb_converter_top hlac_checker u_hlac_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_byte (out_ch.out_byte)
);
`default_nettype wire

### tb/hevc_length_to_annexb_converter_annexb_check.sv
// Watches both stream channels, predicts the Annex B output and compares it byte by byte.
`timescale 1ns / 100ps
module hevc_length_to_annexb_converter_annexb_check
	import hlac_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MASK_W-1:0]    cfg_data,
	hlac_in_if                   in_mon,
	hlac_out_if                  out_mon,
	output int                   fail_count,
	output int                   pending,
	output int                   n_long,
	output int                   n_config,
	output int                   n_short,
	output int                   n_checked
);

	// AUD unit wrapped in start codes; shorter start codes are slices of it
	localparam logic [87:0] AUD_SEQ = 88'h00_00_00_01_46_01_50_00_00_00_01;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              run_last;
	} annexb_byte_t;

	annexb_byte_t annexb_expected[$];
	annexb_byte_t head;

	logic [MASK_W-1:0] vcl_mask;
	logic [MASK_W-1:0] param_mask;
	logic [TIME_W-1:0] cur_time;
	grp_t              group;
	logic [2:0]        len_cnt;
	logic [LEN_W-1:0]  left;
	logic              skipping;
	logic              at_header;

	int errors = 0;
	int expected_count = 0;
	int cnt_long = 0;
	int cnt_config = 0;
	int cnt_short = 0;
	int cnt_checked = 0;

	assign fail_count = errors;
	assign pending    = expected_count;
	assign n_long     = cnt_long;
	assign n_config   = cnt_config;
	assign n_short    = cnt_short;
	assign n_checked  = cnt_checked;

	function automatic void clear_parse();
		len_cnt   = '0;
		left      = '0;
		skipping  = 1'b0;
		at_header = 1'b0;
	endfunction

	function automatic void push_expected(input logic [DATA_W-1:0] b);
		annexb_expected.push_back('{data: b, run_last: 1'b0});
	endfunction

	function automatic void annexb_predict(input logic [DATA_W-1:0] b, input logic first,
		input logic last, input logic [TIME_W-1:0] t);
		logic [5:0]   nal_type;
		grp_t         cls;
		int           base;
		annexb_byte_t tail;
		base = annexb_expected.size();
		if (first) begin
			if (t != cur_time) begin
				cur_time = t;
				group    = GRP_START;
			end
			clear_parse();
		end
		if (at_header) begin
			nal_type  = b[6:1];
			at_header = 1'b0;
			left      = left - 1;
			if (nal_type == AUD_TYPE) begin
				group    = GRP_START;
				skipping = 1'b1;
			end else begin
				if (vcl_mask[nal_type])
					cls = GRP_VCL;
				else if (param_mask[nal_type])
					cls = GRP_CONFIG;
				else
					cls = GRP_OTHER;
				if (group == GRP_START || (group != GRP_OTHER && cls != group)) begin
					for (int i = 0; i < 11; i++)
						push_expected(AUD_SEQ[87-8*i -: 8]);
					cnt_long++;
				end else if (cls == GRP_CONFIG) begin
					for (int i = 0; i < 4; i++)
						push_expected(AUD_SEQ[87-8*i -: 8]);
					cnt_config++;
				end else begin
					for (int i = 1; i < 4; i++)
						push_expected(AUD_SEQ[87-8*i -: 8]);
					cnt_short++;
				end
				push_expected(b);
				group    = cls;
				skipping = 1'b0;
			end
			if (left == 0)
				len_cnt = '0;
		end else if (len_cnt >= LEN_BYTES) begin
			if (left != 0)
				left = left - 1;
			if (!skipping)
				push_expected(b);
			if (left == 0) begin
				len_cnt  = '0;
				skipping = 1'b0;
			end
		end else begin
			left    = {left[LEN_W-9:0], b};
			len_cnt = len_cnt + 3'd1;
			if (len_cnt == LEN_BYTES) begin
				if (left == 0)
					len_cnt = '0;
				else
					at_header = 1'b1;
			end
		end
		if (last)
			clear_parse();
		if (annexb_expected.size() > base) begin
			tail          = annexb_expected.pop_back();
			tail.run_last = 1'b1;
			annexb_expected.push_back(tail);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcl_mask   = VCL_MASK_RST;
			param_mask = PARAM_MASK_RST;
			cur_time   = '0;
			group      = GRP_START;
			clear_parse();
			annexb_expected.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_VCL_MASK)
					vcl_mask = cfg_data;
				else if (cfg_index == CFG_PARAM_MASK)
					param_mask = cfg_data;
			end
			// input side first: a byte never shows output at its own transfer
			if (in_mon.valid && in_mon.ready)
				annexb_predict(in_mon.data_byte, in_mon.packet_first, in_mon.packet_last,
					in_mon.frame_time);
			if (out_mon.valid && out_mon.ready) begin
				if (annexb_expected.size() == 0) begin
					errors++;
					$error("out_byte %02h transferred with nothing expected", out_mon.out_byte);
				end else begin
					head = annexb_expected.pop_front();
					cnt_checked++;
					if (out_mon.out_byte !== head.data) begin
						errors++;
						$error("out_byte: expected %02h, got %02h", head.data, out_mon.out_byte);
					end
					if (out_mon.run_last !== head.run_last) begin
						errors++;
						$error("run_last: expected %0b, got %0b", head.run_last,
							out_mon.run_last);
					end
				end
			end
		end
		expected_count = annexb_expected.size();
	end

endmodule

### tb/hevc_length_to_annexb_converter_top_tb.sv
// Testbench top: clock, reset, packet stimulus, output back-pressure and the verdict.
`timescale 1ns / 100ps
module hevc_length_to_annexb_converter_top_tb;
	import hlac_pkg::*;

	localparam int MAX_GAP      = 14;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_BYTES = 440;
	localparam int N_PHASES     = 5;
	localparam int SETTLE       = 20;
	localparam longint TIMEOUT_NS = 64'd10_000_000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [MASK_W-1:0]    cfg_data;

	hlac_in_if  in_ch();
	hlac_out_if out_ch();

	int fail_count;
	int pending;
	int n_long;
	int n_config;
	int n_short;
	int n_checked;
	int bytes_sent = 0;
	int aud_units = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	hevc_length_to_annexb_converter_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	hevc_length_to_annexb_converter_annexb_check u_annexb_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_mon     (in_ch),
		.out_mon    (out_ch),
		.fail_count (fail_count),
		.pending    (pending),
		.n_long     (n_long),
		.n_config   (n_config),
		.n_short    (n_short),
		.n_checked  (n_checked)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("hevc_length_to_annexb_converter_top_tb NOT OK");
		$finish;
	end

	function automatic int draw_gap();
		if (calm)
			return 0;
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, MAX_GAP);
		return $urandom_range(0, 2);
	endfunction

	function automatic logic [5:0] pick_type();
		case ($urandom_range(0, 5))
			0, 1:    return 6'($urandom_range(0, 21));
			2:       return 6'($urandom_range(32, 34));
			3:       return AUD_TYPE;
			default: return 6'($urandom_range(0, 63));
		endcase
	endfunction

	// 4-byte big-endian length, header with random forbidden/layer bits, then body
	function automatic void add_unit(ref logic [7:0] pkt[$], input logic [31:0] len,
		input logic [5:0] nal_type, input int body);
		pkt.push_back(len[31:24]);
		pkt.push_back(len[23:16]);
		pkt.push_back(len[15:8]);
		pkt.push_back(len[7:0]);
		if (len != 0) begin
			pkt.push_back({1'($urandom), nal_type, 1'($urandom)});
			if (nal_type == AUD_TYPE)
				aud_units++;
			repeat (body) pkt.push_back(8'($urandom));
		end
	endfunction

	function automatic void make_packet(ref logic [7:0] pkt[$]);
		int units;
		int r;
		logic [31:0] len;
		pkt.delete();
		units = $urandom_range(1, 4);
		for (int u = 0; u < units; u++) begin
			r = $urandom_range(0, 19);
			if (r == 0) begin
				add_unit(pkt, '0, 6'd0, 0);
			end else if (r == 1) begin
				// huge length: the packet end cuts the unit off
				len = $urandom | 32'h100;
				add_unit(pkt, len, pick_type(), $urandom_range(0, 3));
				break;
			end else begin
				len = $urandom_range(1, (r < 4) ? 12 : 4);
				add_unit(pkt, len, pick_type(), int'(len) - 1);
			end
		end
		r = $urandom_range(0, 9);
		if (r == 0) begin
			repeat ($urandom_range(1, 3))
				if (pkt.size() > 1)
					void'(pkt.pop_back());
		end else if (r == 1) begin
			// stray bytes: a partial length field at the packet end
			repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
		end
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
		input logic [31:0] t);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.data_byte    <= b;
		in_ch.packet_first <= first;
		in_ch.packet_last  <= last;
		in_ch.frame_time   <= first ? t : 32'($urandom);
		do
			@(posedge clk);
		while (!in_ch.ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_packet(input logic [7:0] pkt[$], input logic [31:0] t,
		input bit marked);
		for (int i = 0; i < pkt.size(); i++)
			send_byte(pkt[i], marked && i == 0, marked && i == pkt.size() - 1, t);
	endtask

	// sender stops and waits for every expected byte, plus a margin
	task automatic drain();
		in_ch.valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// receiver: random stalls per transfer, one long hold-off on request
	initial begin
		int stall;
		bit holding;
		out_ch.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			holding = hold_req;
			stall   = holding ? HOLD_CYCLES : draw_gap();
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			if (holding)
				hold_req = 1'b0;
			out_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_ch.valid);
			@(negedge clk);
		end
	end

	initial begin
		logic [7:0] pkt[$];
		logic [31:0] pkt_time;
		logic [MASK_W-1:0] vmask;
		logic [MASK_W-1:0] pmask;
		int goal;
		int pkt_no;
		bit marked;
		in_ch.valid        = 1'b0;
		in_ch.data_byte    = '0;
		in_ch.packet_first = 1'b0;
		in_ch.packet_last  = 1'b0;
		in_ch.frame_time   = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_VCL_MASK;
		cfg_data  = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// zero length, config long then 4-byte, VCL change, unit cut at packet end
		pkt.delete();
		add_unit(pkt, 32'd0, 6'd0, 0);
		add_unit(pkt, 32'd1, 6'd32, 0);
		add_unit(pkt, 32'd1, 6'd33, 0);
		add_unit(pkt, 32'd3, 6'd1, 1);
		send_packet(pkt, 32'h0, 1'b1);
		// time change, dropped AUD, other twice, partial length at the end
		pkt.delete();
		add_unit(pkt, 32'd1, AUD_TYPE, 0);
		add_unit(pkt, 32'd1, 6'd40, 0);
		add_unit(pkt, 32'd1, 6'd40, 0);
		pkt.push_back(8'h00);
		pkt.push_back(8'h00);
		send_packet(pkt, 32'hFFFF_FFFF, 1'b1);
		// one-byte packet: first and last together
		pkt = '{8'hFF};
		send_packet(pkt, 32'hFFFF_FFFF, 1'b1);
		pkt_time = 32'hFFFF_FFFF;

		for (int phase = 0; phase < N_PHASES; phase++) begin
			drain();
			case (phase)
				1: begin
					vmask = '1;
					pmask = '1;
				end
				2: begin
					vmask = '0;
					pmask = '0;
				end
				3: begin
					vmask = {32'($urandom), 32'($urandom)};
					pmask = {32'($urandom), 32'($urandom)};
				end
				default: begin
					vmask = VCL_MASK_RST;
					pmask = PARAM_MASK_RST;
				end
			endcase
			if (phase != 0) begin
				write_reg(CFG_VCL_MASK, vmask);
				write_reg(CFG_PARAM_MASK, pmask);
			end
			if (phase == 1)
				hold_req = 1'b1;
			goal   = bytes_sent + RANDOM_BYTES / N_PHASES;
			pkt_no = 0;
			while (bytes_sent < goal) begin
				make_packet(pkt);
				case ($urandom_range(0, 7))
					0:       pkt_time = 32'($urandom);
					1:       pkt_time = '0;
					default: ;
				endcase
				marked = $urandom_range(0, 15) != 0;
				// back-to-back transfers right after the hold-off request fill the block
				calm = (phase == 1 && pkt_no < 4) || $urandom_range(0, 5) == 0;
				send_packet(pkt, pkt_time, marked);
				pkt_no++;
			end
			calm = 1'b0;
		end
		drain();

		$display("Sent %0d bytes over %0d mask settings, %0d AUD units; checked %0d output bytes",
			bytes_sent, N_PHASES, aud_units, n_checked);
		$display("Prefixes seen: %0d long, %0d config, %0d short; one %0d-cycle output hold-off",
			n_long, n_config, n_short, HOLD_CYCLES);
		if (fail_count == 0)
			$display("hevc_length_to_annexb_converter_top_tb OK");
		else
			$display("hevc_length_to_annexb_converter_top_tb NOT OK");
		$finish;
	end

endmodule
